### hw/rtl/cube_error_range_metric_assert.svh
// Assertion macros shared by the cube error range metric RTL.
`ifndef CUBE_ERROR_RANGE_METRIC_ASSERT_SVH
`define CUBE_ERROR_RANGE_METRIC_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CERM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CERM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/cerm_pkg.sv
package cerm_pkg;

	// Width of the Q fixed-point relative error.
	localparam int unsigned RATIO_W = 32;
	localparam logic [RATIO_W-1:0] RATIO_TOP = '1;

	// Queue occupancy flags seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} cerm_qstat_t;

endpackage

### hw/rtl/cerm_front.sv
module cerm_front
	import cerm_pkg::*;
#(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] original_sample,
	input  logic signed [SAMPLE_BITS-1:0] decoded_sample,
	input  logic                          last,
	input  cerm_qstat_t                   q_stat,
	output logic                          push,
	output logic signed [3*SAMPLE_BITS-3:0] push_high,
	output logic signed [3*SAMPLE_BITS-3:0] push_low,
	output logic        [3*SAMPLE_BITS-3:0] push_diff
);

	localparam int unsigned SB = SAMPLE_BITS;
	localparam int unsigned CW = 3 * SB - 2;

	logic adv;

	logic                 v_s1, v_s2, v_s3;
	logic                 last_s1, last_s2, last_s3;
	logic signed [SB-1:0] o_s1, d_s1, o_s2, d_s2;
	logic signed [2*SB-1:0] osq_s2, dsq_s2;
	logic signed [CW-1:0] oc_s3, dc_s3;

	logic signed [3*SB-1:0] oprod, dprod;
	logic signed [CW:0]     cdiff;
	logic signed [CW:0]     cdiff_abs;
	logic        [CW-1:0]   cur_diff;

	logic signed [CW-1:0] low_q, high_q;
	logic        [CW-1:0] dmax_q;
	logic                 seen_q;
	logic signed [CW-1:0] low_n, high_n;
	logic        [CW-1:0] dmax_n;

	// Advance the whole pipe only while the queue has room.
	assign adv      = !q_stat.full;
	assign in_stall = q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign oprod = osq_s2 * o_s2;
	assign dprod = dsq_s2 * d_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			o_s1    <= original_sample;
			d_s1    <= decoded_sample;
			last_s1 <= last;
			osq_s2  <= o_s1 * o_s1;
			dsq_s2  <= d_s1 * d_s1;
			o_s2    <= o_s1;
			d_s2    <= d_s1;
			last_s2 <= last_s1;
			oc_s3   <= $signed(oprod[CW-1:0]);
			dc_s3   <= $signed(dprod[CW-1:0]);
			last_s3 <= last_s2;
		end
	end

	assign cdiff     = {oc_s3[CW-1], oc_s3} - {dc_s3[CW-1], dc_s3};
	assign cdiff_abs = cdiff[CW] ? -cdiff : cdiff;
	assign cur_diff  = cdiff_abs[CW-1:0];

	// The first pair of a set seeds the running values.
	always_comb begin
		low_n  = (!seen_q || oc_s3 < low_q)     ? oc_s3    : low_q;
		high_n = (!seen_q || oc_s3 > high_q)    ? oc_s3    : high_q;
		dmax_n = (!seen_q || cur_diff > dmax_q) ? cur_diff : dmax_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			dmax_q <= '0;
			seen_q <= 1'b0;
		end else if (adv && v_s3) begin
			low_q  <= low_n;
			high_q <= high_n;
			dmax_q <= dmax_n;
			seen_q <= !last_s3;
		end
	end

	assign push      = adv && v_s3 && last_s3;
	assign push_high = high_n;
	assign push_low  = low_n;
	assign push_diff = dmax_n;

endmodule

### hw/rtl/cerm_queue.sv
`include "cube_error_range_metric_assert.svh"

module cerm_queue
	import cerm_pkg::*;
#(
	parameter int unsigned CW = 46
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic signed [CW-1:0] push_high,
	input  logic signed [CW-1:0] push_low,
	input  logic        [CW-1:0] push_diff,
	input  logic                 pop,
	output logic signed [CW-1:0] head_high,
	output logic signed [CW-1:0] head_low,
	output logic        [CW-1:0] head_diff,
	output cerm_qstat_t          q_stat
);

	logic signed [CW-1:0] high_mem [2];
	logic signed [CW-1:0] low_mem  [2];
	logic        [CW-1:0] diff_mem [2];
	logic                 wr_ptr_q, rd_ptr_q;
	logic [1:0]           count_q;

	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			high_mem[wr_ptr_q] <= push_high;
			low_mem[wr_ptr_q]  <= push_low;
			diff_mem[wr_ptr_q] <= push_diff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_high = high_mem[rd_ptr_q];
	assign head_low  = low_mem[rd_ptr_q];
	assign head_diff = diff_mem[rd_ptr_q];

	`CERM_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !q_stat.full, "push into full queue")
	`CERM_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, !q_stat.empty, "pop from empty queue")
	`CERM_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q != 2'd3, "queue count overflow")

endmodule

### hw/rtl/cerm_back.sv
`include "cube_error_range_metric_assert.svh"

module cerm_back
	import cerm_pkg::*;
#(
	parameter int unsigned CW            = 46,
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cerm_qstat_t          q_stat,
	input  logic signed [CW-1:0] head_high,
	input  logic signed [CW-1:0] head_low,
	input  logic        [CW-1:0] head_diff,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [CW-1:0] max_cube,
	output logic signed [CW-1:0] min_cube,
	output logic        [CW-1:0] max_cube_difference,
	output logic [RATIO_W-1:0]   relative_error,
	output logic                 range_zero,
	output logic                 ratio_saturated
);

	localparam int unsigned DW    = CW + 1;
	localparam int unsigned NW    = CW + FRACTION_BITS;
	localparam int unsigned CNT_W = $clog2(NW);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic signed [CW:0]   range_s;
	logic        [DW-1:0] den_q;
	logic        [DW-1:0] rem_q;
	logic        [NW-1:0] num_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [RATIO_W-1:0]   quo_q;
	logic                 sat_q;
	logic                 zero_q;

	logic [DW:0] trial;
	logic [DW:0] trial_sub;
	logic        qbit;

	assign pop     = (state_q == ST_IDLE) && !q_stat.empty;
	assign range_s = {head_high[CW-1], head_high} - {head_low[CW-1], head_low};

	// One restoring-division step per cycle, numerator MSB first.
	assign trial     = {rem_q, num_q[NW-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign qbit      = !trial_sub[DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop)
						state_q <= (range_s == '0) ? ST_EMIT : ST_RUN;
				end
				ST_RUN: begin
					if (cnt_q == '0)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					max_cube            <= head_high;
					min_cube            <= head_low;
					max_cube_difference <= head_diff;
					den_q               <= DW'($unsigned(range_s));
					num_q               <= NW'(head_diff) << FRACTION_BITS;
					rem_q               <= '0;
					cnt_q               <= CNT_W'(NW - 1);
					quo_q               <= '0;
					sat_q               <= 1'b0;
					zero_q              <= (range_s == '0);
				end
			end
			ST_RUN: begin
				rem_q <= qbit ? trial_sub[DW-1:0] : trial[DW-1:0];
				num_q <= num_q << 1;
				quo_q <= {quo_q[RATIO_W-2:0], qbit};
				// Flag any quotient bit above the 32-bit result.
				if (qbit && (32'(cnt_q) >= 32'(RATIO_W)))
					sat_q <= 1'b1;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: ;
		endcase
	end

	assign out_valid       = (state_q == ST_EMIT);
	assign range_zero      = zero_q;
	assign ratio_saturated = sat_q && !zero_q;
	assign relative_error  = zero_q ? '0 : (sat_q ? RATIO_TOP : quo_q);

	`CERM_ASSERT_NOW(a_den_nonzero, clk, arst_n, state_q == ST_RUN, den_q != '0,
		"division started with zero range")
	`CERM_ASSERT_NOW(a_zero_result, clk, arst_n, out_valid && range_zero,
		relative_error == '0 && !ratio_saturated, "zero range with nonzero ratio")
	`CERM_ASSERT_NEXT(a_pop_leaves_idle, clk, arst_n, pop,
		state_q == ST_RUN || state_q == ST_EMIT, "pop did not start work")

endmodule

### hw/rtl/cube_error_range_metric.sv
// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------------
// in      | in_valid / in_stall  | original_sample, decoded_sample, last
// out     | out_valid / out_stall| max_cube, min_cube, max_cube_difference,
//         |                      | relative_error, range_zero, ratio_saturated
//
// Front: one pair per cycle while the queue is not full; an accepted pair is squared, cubed
// and then folded into the running registers, and a closing pair pushes its set into a
// two-deep queue. Back: pop and load a set, then run a restoring divider at one quotient
// bit per cycle, then emit the result; a zero range skips the divider. arst_n clears
// valid, count and state registers. in_stall rises only while the queue is full;
// out_stall holds the result beat.
module cube_error_range_metric
	import cerm_pkg::*;
#(
	parameter int unsigned SAMPLE_BITS   = 16,
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [SAMPLE_BITS-1:0]   original_sample,
	input  logic signed [SAMPLE_BITS-1:0]   decoded_sample,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [3*SAMPLE_BITS-3:0] max_cube,
	output logic signed [3*SAMPLE_BITS-3:0] min_cube,
	output logic        [3*SAMPLE_BITS-3:0] max_cube_difference,
	output logic [RATIO_W-1:0]              relative_error,
	output logic                            range_zero,
	output logic                            ratio_saturated
);

	// Cube width: a signed SAMPLE_BITS value cubed fits in 3*SAMPLE_BITS-2 bits.
	localparam int unsigned CW = 3 * SAMPLE_BITS - 2;

	cerm_qstat_t          q_stat;
	logic                 push, pop;
	logic signed [CW-1:0] push_high, push_low;
	logic        [CW-1:0] push_diff;
	logic signed [CW-1:0] head_high, head_low;
	logic        [CW-1:0] head_diff;

	// Front: cube both samples and fold them into the running set values.
	cerm_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.original_sample(original_sample),
		.decoded_sample (decoded_sample),
		.last           (last),
		.q_stat         (q_stat),
		.push           (push),
		.push_high      (push_high),
		.push_low       (push_low),
		.push_diff      (push_diff)
	);

	// Queue: hold finished set summaries while the divider is busy.
	cerm_queue #(
		.CW(CW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_high(push_high),
		.push_low (push_low),
		.push_diff(push_diff),
		.pop      (pop),
		.head_high(head_high),
		.head_low (head_low),
		.head_diff(head_diff),
		.q_stat   (q_stat)
	);

	// Back: divide the largest difference by the cube range and emit the beat.
	cerm_back #(
		.CW           (CW),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.q_stat             (q_stat),
		.head_high          (head_high),
		.head_low           (head_low),
		.head_diff          (head_diff),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.max_cube           (max_cube),
		.min_cube           (min_cube),
		.max_cube_difference(max_cube_difference),
		.relative_error     (relative_error),
		.range_zero         (range_zero),
		.ratio_saturated    (ratio_saturated)
	);

endmodule
